// File: src/cpcu_pkg.sv
`timescale 1ns / 1ps

package cpcu_pkg;

  // bus access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // register map
  localparam logic [11:0] OFS_BOOT_LO    = 12'h020;
  localparam logic [11:0] OFS_BOOT_HI    = 12'h028;
  localparam logic [11:0] OFS_ACK_CNT    = 12'h030;
  localparam logic [11:0] OFS_SW_CTRL    = 12'h038;
  localparam logic [11:0] OFS_MODE_CTRL  = 12'h100;
  localparam logic [11:0] OFS_IRQ_EV     = 12'h300;
  localparam logic [11:0] OFS_IRQ_MASK   = 12'h400;
  localparam logic [11:0] OFS_ENTRY_TMR  = 12'h600;
  localparam logic [11:0] OFS_DBG0       = 12'h800;
  localparam logic [11:0] OFS_DBG1       = 12'h808;
  localparam logic [11:0] OFS_DBG2       = 12'h810;
  localparam logic [11:0] OFS_MODE_STAT  = 12'h900;
  localparam logic [11:0] OFS_RSVD_A     = 12'hA00;
  localparam logic [11:0] OFS_ACTIVE_EN  = 12'hB00;
  localparam logic [11:0] OFS_RSVD_C     = 12'hC00;

  // power mode encodings
  localparam logic [3:0] MODE_OFF      = 4'h0;
  localparam logic [3:0] MODE_OFF_EMU  = 4'h1;
  localparam logic [3:0] MODE_ON       = 4'h8;
  localparam logic [3:0] MODE_WARM_RST = 4'h9;

  // one-hot mode status
  localparam logic [9:0] STAT_OFF     = 10'h001;
  localparam logic [9:0] STAT_OFF_EMU = 10'h002;
  localparam logic [9:0] STAT_ON      = 10'h100;

  // interrupt events
  localparam logic [7:0] EV_DONE    = 8'h01;
  localparam logic [7:0] EV_INVALID = 8'h80;
  localparam logic [7:0] EV_ALL     = 8'hC5;

  // reset values
  localparam logic [15:0] ACK_CNT_RST   = 16'h8000;
  localparam logic [1:0]  SW_CTRL_RST   = 2'h3;
  localparam logic [5:0]  MODE_CTRL_RST = 6'h20;
  localparam logic [7:0]  IRQ_MASK_RST  = 8'hC4;
  localparam logic [15:0] ENTRY_TMR_RST = 16'h8000;

  typedef struct packed {
    logic        command;
    logic [11:0] register_offset;
    logic [31:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic        core_power_off;
    logic        access_error;
    logic        release_ready;
    logic [63:0] release_address;
  } out_word_t;

endpackage

// File: src/core_power_control_unit.sv
`timescale 1ns / 1ps

// channel  dir  handshake             word
// in_      in   in_valid / in_stall   in_word  (command, offset, write data)
// out_     out  out_valid / out_stall out_word (read data, irq, flags, boot address)
// cfg_     in   cfg_wr_en             cfg_wr_data (core present)
//
// one access per cycle while out_ is not stalled: a word is latched in the input
// stage, decoded and applied to the bank as it advances; its result appears on out_
// at that advance. the register update and the result register load share one edge.
// rst_n (synchronous) resets valid flags and the bank, but not the held words.
// out_stall holds the result; the input stage then fills and in_stall rises.

module core_power_control_unit
  import cpcu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;

  logic        core_present_r;
  logic [31:0] boot_lo_r,    boot_lo_nxt;
  logic [31:0] boot_hi_r,    boot_hi_nxt;
  logic [15:0] ack_cnt_r,    ack_cnt_nxt;
  logic [1:0]  sw_ctrl_r,    sw_ctrl_nxt;
  logic [5:0]  mode_ctrl_r,  mode_ctrl_nxt;
  logic [7:0]  irq_ev_r,     irq_ev_nxt;
  logic [7:0]  irq_mask_r,   irq_mask_nxt;
  logic [15:0] entry_tmr_r,  entry_tmr_nxt;
  logic [2:0]  dbg_r,        dbg_nxt;
  logic        active_en_r,  active_en_nxt;
  logic [9:0]  mode_stat_r,  mode_stat_nxt;

  logic      accept;
  logic      advance;
  out_word_t res;
  logic [3:0] new_mode;
  logic       ready;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign new_mode  = s1_word_r.write_data[3:0];

  always_comb begin
    boot_lo_nxt   = boot_lo_r;
    boot_hi_nxt   = boot_hi_r;
    ack_cnt_nxt   = ack_cnt_r;
    sw_ctrl_nxt   = sw_ctrl_r;
    mode_ctrl_nxt = mode_ctrl_r;
    irq_ev_nxt    = irq_ev_r;
    irq_mask_nxt  = irq_mask_r;
    entry_tmr_nxt = entry_tmr_r;
    dbg_nxt       = dbg_r;
    active_en_nxt = active_en_r;
    mode_stat_nxt = mode_stat_r;
    res           = '0;

    if (s1_word_r.command == CMD_READ) begin
      unique case (s1_word_r.register_offset)
        OFS_BOOT_LO:   res.read_data = boot_lo_r;
        OFS_BOOT_HI:   res.read_data = boot_hi_r;
        OFS_ACK_CNT:   res.read_data = {16'h0, ack_cnt_r};
        OFS_SW_CTRL:   res.read_data = {30'h0, sw_ctrl_r};
        OFS_MODE_CTRL: res.read_data = {mode_ctrl_r[5], 23'h0, mode_ctrl_r[4], 3'h0,
                                        mode_ctrl_r[3:0]};
        OFS_IRQ_EV:    res.read_data = {24'h0, irq_ev_r};
        OFS_IRQ_MASK:  res.read_data = {24'h0, irq_mask_r};
        OFS_ENTRY_TMR: res.read_data = {16'h0, entry_tmr_r};
        OFS_DBG0:      res.read_data = {31'h0, dbg_r[0]};
        OFS_DBG1:      res.read_data = {31'h0, dbg_r[1]};
        OFS_DBG2:      res.read_data = {31'h0, dbg_r[2]};
        OFS_MODE_STAT: res.read_data = {22'h0, mode_stat_r};
        OFS_RSVD_A:    res.read_data = '0;
        OFS_ACTIVE_EN: res.read_data = {23'h0, active_en_r, 8'h0};
        OFS_RSVD_C:    res.read_data = '0;
        default:       res.access_error = 1'b1;
      endcase
    end else begin
      unique case (s1_word_r.register_offset)
        OFS_BOOT_LO:   boot_lo_nxt = s1_word_r.write_data;
        OFS_BOOT_HI:   boot_hi_nxt = s1_word_r.write_data;
        OFS_ACK_CNT:   ack_cnt_nxt = s1_word_r.write_data[15:0];
        OFS_SW_CTRL:   sw_ctrl_nxt = s1_word_r.write_data[1:0];
        OFS_MODE_CTRL: begin
          mode_ctrl_nxt = {s1_word_r.write_data[31], s1_word_r.write_data[7], new_mode};
          if (new_mode != mode_ctrl_r[3:0]) begin
            priority if (new_mode == MODE_ON || new_mode == MODE_WARM_RST) begin
              if (core_present_r) begin
                mode_stat_nxt = STAT_ON;
                irq_ev_nxt    = irq_ev_r | EV_DONE;
              end
            end else if (new_mode == MODE_OFF || new_mode == MODE_OFF_EMU) begin
              if (core_present_r) begin
                mode_stat_nxt      = (new_mode == MODE_OFF) ? STAT_OFF : STAT_OFF_EMU;
                irq_ev_nxt         = irq_ev_r | EV_DONE;
                res.core_power_off = 1'b1;
              end
            end else begin
              // unsupported mode, raised even with no core fitted
              irq_ev_nxt = irq_ev_r | EV_INVALID;
            end
          end
        end
        OFS_IRQ_EV:    irq_ev_nxt = irq_ev_r & ~(s1_word_r.write_data[7:0] & EV_ALL);
        OFS_IRQ_MASK:  irq_mask_nxt = s1_word_r.write_data[7:0] & EV_ALL;
        OFS_ENTRY_TMR: entry_tmr_nxt = s1_word_r.write_data[15:0];
        OFS_DBG0:      dbg_nxt[0] = s1_word_r.write_data[0];
        OFS_DBG1:      dbg_nxt[1] = s1_word_r.write_data[0];
        OFS_DBG2:      dbg_nxt[2] = s1_word_r.write_data[0];
        OFS_ACTIVE_EN: active_en_nxt = s1_word_r.write_data[8];
        default:       res.access_error = 1'b1;
      endcase
    end

    // status reflects the bank after this word
    ready = (mode_ctrl_nxt[3:0] == MODE_ON || mode_ctrl_nxt[3:0] == MODE_WARM_RST) &&
            ({boot_hi_nxt, boot_lo_nxt} != 64'h0);
    res.irq_line        = |(irq_ev_nxt & ~irq_mask_nxt & EV_ALL);
    res.release_ready   = ready;
    res.release_address = ready ? {boot_hi_nxt, boot_lo_nxt} : 64'h0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      core_present_r <= 1'b1;
      boot_lo_r      <= '0;
      boot_hi_r      <= '0;
      ack_cnt_r      <= ACK_CNT_RST;
      sw_ctrl_r      <= SW_CTRL_RST;
      mode_ctrl_r    <= MODE_CTRL_RST;
      irq_ev_r       <= '0;
      irq_mask_r     <= IRQ_MASK_RST;
      entry_tmr_r    <= ENTRY_TMR_RST;
      dbg_r          <= '0;
      active_en_r    <= 1'b1;
      mode_stat_r    <= STAT_OFF;
    end else begin
      if (cfg_wr_en) begin
        core_present_r <= cfg_wr_data;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        boot_lo_r   <= boot_lo_nxt;
        boot_hi_r   <= boot_hi_nxt;
        ack_cnt_r   <= ack_cnt_nxt;
        sw_ctrl_r   <= sw_ctrl_nxt;
        mode_ctrl_r <= mode_ctrl_nxt;
        irq_ev_r    <= irq_ev_nxt;
        irq_mask_r  <= irq_mask_nxt;
        entry_tmr_r <= entry_tmr_nxt;
        dbg_r       <= dbg_nxt;
        active_en_r <= active_en_nxt;
        mode_stat_r <= mode_stat_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_stat_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(mode_stat_r))
    else $error("mode status not one-hot");

  a_ev_defined: assert property (@(posedge clk) disable iff (!rst_n)
    (irq_ev_r & ~(EV_DONE | EV_INVALID)) == 8'h0)
    else $error("undefined interrupt event set");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with an empty pipe");

  a_ready_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.release_ready |-> out_word_r.release_address != 64'h0)
    else $error("release ready with zero boot address");

  a_pwr_off_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.core_power_off |->
      (mode_stat_r == STAT_OFF || mode_stat_r == STAT_OFF_EMU))
    else $error("power-off word without off status");
`endif

endmodule
